// ===== sv/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the fuzzy subsequence scorer: item opcodes,
// field widths, separator characters, score bonuses and penalties, the pattern
// store write request and the finished string report.
// ----------------------------------------------------------------------------
package fss_pkg;

  // Default depth of the pattern store.
  localparam int PATTERN_MAX_DEFAULT = 64;

  // Fixed widths of the item and register fields.
  localparam int IDX_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 7;
  localparam int SCORE_W = 16;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_LAST = 2'd2,
    OP_END  = 2'd3
  } op_t;

  // Score contributions.
  localparam logic signed [6:0] GAIN_HIT      = 7'sd1;
  localparam logic signed [6:0] GAIN_BOUNDARY = 7'sd10;
  localparam logic signed [6:0] GAIN_CONSEC   = 7'sd15;
  localparam logic signed [6:0] GAIN_FIRST    = 7'sd8;
  localparam logic signed [6:0] COST_LEAD     = -7'sd3;
  localparam logic signed [6:0] COST_MISS     = -7'sd1;
  localparam logic [1:0]        LEAD_MAX      = 2'd3;

  // Saturation bounds of the score.
  localparam logic signed [SCORE_W-1:0] SCORE_HI = 16'sh7FFF;
  localparam logic signed [SCORE_W-1:0] SCORE_LO = 16'sh8000;

  // Characters of interest.
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  // Write request into the pattern store.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [CHAR_W-1:0] data;
  } pat_wr_t;

  // One finished string report.
  typedef struct packed {
    logic                      valid;
    logic                      matched;
    logic signed [SCORE_W-1:0] score;
  } fss_result_t;

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  // ASCII-only case folding to lower case.
  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    return is_upper(c) ? c + CASE_OFS : c;
  endfunction

  function automatic logic is_separator(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_UNDER) || (c == CH_DASH) ||
           (c == CH_SLASH) || (c == CH_DOT) || (c == CH_HASH) ||
           (c == CH_COLON);
  endfunction

endpackage

// ===== sv/fss_pattern_mem.sv =====
// ----------------------------------------------------------------------------
// fss_pattern_mem
// Pattern store: one write port and one read port with registered read data.
// A write to the address being read is forwarded to the read data.
// ----------------------------------------------------------------------------
module fss_pattern_mem #(
  parameter int PatternMax = fss_pkg::PATTERN_MAX_DEFAULT,
  parameter int AddrW      = (PatternMax > 1) ? $clog2(PatternMax) : 1
) (
  input  logic                       clk,
  input  fss_pkg::pat_wr_t           wr,
  input  logic [AddrW-1:0]           rd_addr,
  output logic [fss_pkg::CHAR_W-1:0] rd_data
);
  import fss_pkg::*;

  localparam int IdxExtW = (AddrW > IDX_W) ? AddrW : IDX_W;

  logic [CHAR_W-1:0]  mem [PatternMax];
  logic [IdxExtW-1:0] idx_ext;
  logic [AddrW-1:0]   wr_addr;

  // The write enable is only set for slots inside the store.
  assign idx_ext = IdxExtW'(wr.index);
  assign wr_addr = idx_ext[AddrW-1:0];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // Registered read with write-first forwarding.
  always_ff @(posedge clk) begin
    if (wr.en && (wr_addr == rd_addr)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fss_score_core.sv =====
// ----------------------------------------------------------------------------
// fss_score_core
// Per-string matching state and scoring. One request is processed in each cycle with fire set:
// the current pattern byte is held in a register, and the memory read port
// prefetches the byte after it so that a hit can advance in the next cycle.
// ----------------------------------------------------------------------------
module fss_score_core #(
  parameter int PatternMax = fss_pkg::PATTERN_MAX_DEFAULT,
  parameter int AddrW      = (PatternMax > 1) ? $clog2(PatternMax) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  fss_pkg::op_t               op,
  input  logic [fss_pkg::IDX_W-1:0]  pattern_index,
  input  logic [fss_pkg::CHAR_W-1:0] char_byte,
  input  logic [fss_pkg::LEN_W-1:0]  pat_len,
  input  logic [fss_pkg::CHAR_W-1:0] mem_rdata,
  output fss_pkg::pat_wr_t           wr,
  output logic [AddrW-1:0]           rd_addr,
  output fss_pkg::fss_result_t       res
);
  import fss_pkg::*;

  localparam int PosW    = $clog2(PatternMax + 1);
  localparam int IdxExtW = (AddrW > IDX_W) ? AddrW : IDX_W;
  localparam int CmpW    = (IdxExtW > PosW) ? IdxExtW : PosW;

  // State registers.
  logic [PosW-1:0]           pos, pos_next;
  logic signed [SCORE_W-1:0] run_score, run_score_next;
  logic [1:0]                lead_count, lead_count_next;
  logic                      prev_hit, prev_hit_next;
  logic                      prev_separator, prev_separator_next;
  logic                      started, started_next;
  logic                      prev_lower, prev_lower_next;
  logic                      at_start, at_start_next;
  logic [CHAR_W-1:0]         cur_char, cur_char_next;
  logic [CHAR_W-1:0]         slot0, slot0_next;
  fss_result_t               res_next;

  // Combinational helpers.
  logic [PosW-1:0]           eff_len;
  logic                      take, finish, load_ok;
  logic                      camel, boundary, hit;
  logic signed [6:0]         delta;
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] sat_score;

  // Length in use, clamped to the store depth.
  assign eff_len = (int'(pat_len) > PatternMax) ? PosW'(PatternMax) : PosW'(pat_len);

  assign take    = fire && ((op == OP_TEXT) || (op == OP_LAST));
  assign finish  = fire && ((op == OP_LAST) || (op == OP_END));
  assign load_ok = fire && (op == OP_LOAD) && (int'(pattern_index) < PatternMax);

  // Pattern store write request.
  assign wr.en    = load_ok;
  assign wr.index = pattern_index;
  assign wr.data  = char_byte;

  // Hit test and bonus conditions for the incoming text byte.
  assign camel    = prev_lower && is_upper(char_byte);
  assign boundary = prev_separator || camel;
  assign hit      = (pos < eff_len) && (fold(char_byte) == fold(cur_char));

  // Score change for this byte.
  always_comb begin
    delta = 7'sd0;
    if (hit) begin
      delta = GAIN_HIT;
      if (boundary) delta = delta + GAIN_BOUNDARY;
      if (prev_hit) delta = delta + GAIN_CONSEC;
      if (at_start) delta = delta + GAIN_FIRST;
    end else if (!started && (lead_count < LEAD_MAX)) begin
      delta = COST_LEAD;
    end else if (started) begin
      delta = COST_MISS;
    end
  end

  // Saturating accumulate.
  assign sum = (SCORE_W + 1)'(run_score) + (SCORE_W + 1)'(delta);
  always_comb begin
    if (sum > (SCORE_W + 1)'(SCORE_HI)) begin
      sat_score = SCORE_HI;
    end else if (sum < (SCORE_W + 1)'(SCORE_LO)) begin
      sat_score = SCORE_LO;
    end else begin
      sat_score = sum[SCORE_W-1:0];
    end
  end

  // Next-state logic.
  always_comb begin
    pos_next            = pos;
    run_score_next      = run_score;
    lead_count_next     = lead_count;
    prev_hit_next       = prev_hit;
    prev_separator_next = prev_separator;
    started_next        = started;
    prev_lower_next     = prev_lower;
    at_start_next       = at_start;
    cur_char_next       = cur_char;
    slot0_next          = slot0;
    res_next            = '0;

    // Text byte: advance the match state.
    if (take) begin
      run_score_next = sat_score;
      if (hit) begin
        pos_next      = pos + PosW'(1);
        cur_char_next = mem_rdata;
        prev_hit_next = 1'b1;
        started_next  = 1'b1;
      end else begin
        prev_hit_next = 1'b0;
        if (!started && (lead_count < LEAD_MAX)) begin
          lead_count_next = lead_count + 2'd1;
        end
      end
      prev_separator_next = is_separator(char_byte);
      prev_lower_next     = is_lower(char_byte);
      at_start_next       = 1'b0;
    end

    // End of string: report, then return to the fresh-string state.
    if (finish) begin
      res_next.valid = 1'b1;
      if (eff_len == '0) begin
        res_next.matched = 1'b1;
        res_next.score   = '0;
      end else begin
        res_next.matched = (pos_next >= eff_len);
        res_next.score   = (pos_next >= eff_len) ? run_score_next : '0;
      end
      pos_next            = '0;
      run_score_next      = '0;
      lead_count_next     = '0;
      prev_hit_next       = 1'b0;
      prev_separator_next = 1'b1;
      started_next        = 1'b0;
      prev_lower_next     = 1'b0;
      at_start_next       = 1'b1;
      cur_char_next       = slot0;
    end

    // Pattern load: keep the held copies coherent with the store.
    if (load_ok) begin
      if (CmpW'(pattern_index) == CmpW'(pos)) begin
        cur_char_next = char_byte;
      end
      if (pattern_index == '0) begin
        slot0_next = char_byte;
      end
    end
  end

  // The report goes straight to the output register of the top level.
  assign res = res_next;

  // Prefetch the byte that follows the next match position.
  assign rd_addr = AddrW'(pos_next + PosW'(1));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      run_score      <= '0;
      lead_count     <= '0;
      prev_hit       <= 1'b0;
      prev_separator <= 1'b1;
      started        <= 1'b0;
      prev_lower     <= 1'b0;
      at_start       <= 1'b1;
    end else begin
      pos            <= pos_next;
      run_score      <= run_score_next;
      lead_count     <= lead_count_next;
      prev_hit       <= prev_hit_next;
      prev_separator <= prev_separator_next;
      started        <= started_next;
      prev_lower     <= prev_lower_next;
      at_start       <= at_start_next;
    end
  end

  // Held pattern bytes.
  always_ff @(posedge clk) begin
    cur_char <= cur_char_next;
    slot0    <= slot0_next;
  end

endmodule

// ===== sv/fuzzy_subsequence_scorer.sv =====
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Greedy, case-insensitive fuzzy subsequence match of a byte stream against
// a stored pattern, with a saturated score reported at the end of each string.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   op, pattern_index, char_byte
//   out      output     out_valid / out_ready matched, score
//   cfg      input      cfg_valid / cfg_ready pattern_length
//
// A request is registered at the input and scored from the input register; its
// report, if any, is then registered in the output register. One request per
// cycle is sustained, set by the single scoring stage, unless a closing
// request waits. Reset clears the per-string state and the length register; the
// pattern store holds no reset value. A closing request waits in the input
// register while an untaken report fills the output register, and holds back
// the requests behind it; loads and text bytes never wait there.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer #(
  parameter int PATTERN_MAX = fss_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         op,
  input  logic [fss_pkg::IDX_W-1:0]          pattern_index,
  input  logic [fss_pkg::CHAR_W-1:0]         char_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               matched,
  output logic signed [fss_pkg::SCORE_W-1:0] score,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fss_pkg::LEN_W-1:0]          pattern_length
);
  import fss_pkg::*;

  localparam int AddrW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Input stage.
  logic              s1_valid;
  op_t               s1_op;
  logic [IDX_W-1:0]  s1_index;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_adv;

  logic [LEN_W-1:0]  pat_len;
  pat_wr_t           wr;
  logic [AddrW-1:0]  rd_addr;
  logic [CHAR_W-1:0] rd_data;
  fss_result_t       res;

  // A closing request needs room in the output register.
  assign s1_adv   = s1_valid &&
                    ((s1_op == OP_LOAD) || (s1_op == OP_TEXT) || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op    <= op_t'(op);
      s1_index <= pattern_index;
      s1_char  <= char_byte;
    end
  end

  // Length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len <= '0;
    end else if (cfg_valid) begin
      pat_len <= pattern_length;
    end
  end

  fss_pattern_mem #(
    .PatternMax (PATTERN_MAX),
    .AddrW      (AddrW)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fss_score_core #(
    .PatternMax (PATTERN_MAX),
    .AddrW      (AddrW)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (s1_adv),
    .op            (s1_op),
    .pattern_index (s1_index),
    .char_byte     (s1_char),
    .pat_len       (pat_len),
    .mem_rdata     (rd_data),
    .wr            (wr),
    .rd_addr       (rd_addr),
    .res           (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      matched <= res.matched;
      score   <= res.score;
    end
  end

endmodule
